@@ rtl/core/tcas_pkg.sv @@
// Shared types, constants and the arctangent table for the crossing-angle solver.
package tcas_pkg;

    // Field widths of the transaction payloads.
    localparam int COEF_WIDTH  = 32;
    localparam int ANGLE_WIDTH = 16;
    localparam int TOL_WIDTH   = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd7;

    // Function form codes.
    localparam logic FORM_LINEAR   = 1'b0;
    localparam logic FORM_RATIONAL = 1'b1;

    // Magnitudes are normalized below 2^NORM_BITS before the root and angle stages.
    localparam int NORM_BITS    = 30;
    localparam int CORDIC_STEPS = 31;
    localparam int ZANG_WIDTH   = 32;

    // Lane pipeline depth: normalize (2), square, difference, one square root stage per
    // root bit, vector pre-rotation, the rotation steps and the final rounding stage.
    localparam int LANE_LAT = 6 + NORM_BITS + 1 + CORDIC_STEPS;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                          form;
        logic signed [COEF_WIDTH-1:0]  coef_a;
        logic signed [COEF_WIDTH-1:0]  coef_b;
        logic signed [COEF_WIDTH-1:0]  coef_c;
        logic signed [COEF_WIDTH-1:0]  coef_d;
        logic signed [COEF_WIDTH-1:0]  coef_e;
    } in_item_t;

    typedef struct packed {
        logic                    zero_found;
        logic [ANGLE_WIDTH-1:0]  zero_first;
        logic [ANGLE_WIDTH-1:0]  zero_second;
        logic                    one_found;
        logic [ANGLE_WIDTH-1:0]  one_first;
        logic [ANGLE_WIDTH-1:0]  one_second;
    } out_item_t;

    // One equation p + q cos t + r sin t = 0, with the front's verdict on degeneracy.
    typedef struct packed {
        logic                        ok;
        logic signed [COEF_WIDTH:0]  p;
        logic signed [COEF_WIDTH:0]  q;
        logic signed [COEF_WIDTH:0]  r;
    } pair_req_t;

    typedef struct packed {
        pair_req_t zero;
        pair_req_t one;
    } work_item_t;

    typedef struct packed {
        logic                    found;
        logic [ANGLE_WIDTH-1:0]  first;
        logic [ANGLE_WIDTH-1:0]  second;
    } pair_res_t;

    // atan(2^-i) in 32-bit binary angles.
    function automatic logic [ZANG_WIDTH-1:0] atan_entry(input int idx);
        logic [ZANG_WIDTH-1:0] v;
        unique case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/tcas_front.sv @@
// Front part: holds the tolerance register and turns each input transaction into two equations.
module tcas_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tcas_pkg::TOL_WIDTH-1:0]      cfg_wr_data,
    input  tcas_pkg::in_item_t                  item,
    output tcas_pkg::work_item_t                work
);

    localparam int CW = tcas_pkg::COEF_WIDTH;
    localparam int TW = tcas_pkg::TOL_WIDTH;

    logic [TW-1:0] tol_reg;
    logic [TW-1:0] tol_next;

    logic signed [CW:0] a_x, b_x, c_x, d_x, e_x;
    logic signed [CW:0] p1, q1, r1;
    logic [CW:0]        d_abs;
    logic               parallel;
    logic [2*TW-1:0]    tol_sq;

    // Magnitude of an extended coefficient, which always fits the coefficient width.
    function automatic logic [CW-1:0] mag_of(input logic signed [CW:0] v);
        logic [CW:0] t;
        t = v[CW] ? $unsigned(-v) : $unsigned(v);
        return t[CW-1:0];
    endfunction

    // True when q and r are both within the tolerance circle.
    function automatic logic degenerate(input logic signed [CW:0] q,
                                        input logic signed [CW:0] r,
                                        input logic [TW-1:0] tol,
                                        input logic [2*TW-1:0] tsq);
        logic [CW-1:0]   aq;
        logic [CW-1:0]   ar;
        logic [2*TW:0]   ssum;
        logic            near;
        aq   = mag_of(q);
        ar   = mag_of(r);
        near = (aq <= CW'(tol)) && (ar <= CW'(tol));
        ssum = (2*TW+1)'(aq[TW-1:0] * aq[TW-1:0]) + (2*TW+1)'(ar[TW-1:0] * ar[TW-1:0]);
        return near && (ssum <= (2*TW+1)'(tsq));
    endfunction

    // Tolerance register.
    always_comb
    begin
        tol_next = cfg_wr_en ? cfg_wr_data : tol_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= tcas_pkg::TOL_RESET;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    // Build both equations and flag the degenerate ones.
    always_comb
    begin
        a_x = {item.coef_a[CW-1], item.coef_a};
        b_x = {item.coef_b[CW-1], item.coef_b};
        c_x = {item.coef_c[CW-1], item.coef_c};
        d_x = {item.coef_d[CW-1], item.coef_d};
        e_x = {item.coef_e[CW-1], item.coef_e};
        d_abs  = d_x[CW] ? $unsigned(-d_x) : $unsigned(d_x);
        tol_sq = tol_reg * tol_reg;

        if (item.form == tcas_pkg::FORM_LINEAR)
        begin
            p1 = a_x - d_x;
            q1 = b_x;
            r1 = c_x;
            parallel = d_abs < (CW+1)'(tol_reg);
        end
        else
        begin
            p1 = a_x;
            q1 = b_x - d_x;
            r1 = c_x - e_x;
            parallel = 1'b0;
        end

        work.zero.p  = a_x;
        work.zero.q  = b_x;
        work.zero.r  = c_x;
        work.zero.ok = !parallel && !degenerate(b_x, c_x, tol_reg, tol_sq);
        work.one.p   = p1;
        work.one.q   = q1;
        work.one.r   = r1;
        work.one.ok  = !parallel && !degenerate(q1, r1, tol_reg, tol_sq);
    end

endmodule

@@ rtl/core/tcas_queue.sv @@
// Short flip-flop queue that decouples the front from the back.
module tcas_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tcas_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNTW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/tcas_lane.sv @@
// One solver lane: normalize, square, integer square root and two CORDIC arctangents.
module tcas_lane (
    input  logic                  clk,
    input  logic                  en,
    input  tcas_pkg::pair_req_t   req,
    output tcas_pkg::pair_res_t   res
);

    localparam int CW = tcas_pkg::COEF_WIDTH;
    localparam int NL = tcas_pkg::NORM_BITS;
    localparam int AW = tcas_pkg::ANGLE_WIDTH;
    localparam int ZW = tcas_pkg::ZANG_WIDTH;
    localparam int CS = tcas_pkg::CORDIC_STEPS;
    localparam int KW = $clog2(CW + 1);
    localparam int EW = (CW > NL) ? CW : NL;
    localparam int RW = 2 * NL + 2;
    localparam int XW = NL + 6;

    function automatic logic [CW-1:0] mag_of(input logic signed [CW:0] v);
        logic [CW:0] t;
        t = v[CW] ? $unsigned(-v) : $unsigned(v);
        return t[CW-1:0];
    endfunction

    function automatic logic [NL-1:0] shr(input logic [CW-1:0] m, input logic [KW-1:0] k);
        logic [EW-1:0] t;
        t = EW'(m) >> k;
        return t[NL-1:0];
    endfunction

    function automatic logic signed [NL:0] apply_sign(input logic [NL-1:0] m, input logic s);
        logic signed [NL:0] t;
        t = $signed({1'b0, m});
        return s ? -t : t;
    endfunction

    // Stage 1: magnitudes and the common normalizing shift.
    logic [CW-1:0] pm_c, qm_c, rm_c, mx_c;
    logic [KW-1:0] k_c;
    logic [CW-1:0] pm1_reg, qm1_reg, rm1_reg;
    logic          ps1_reg, qs1_reg, rs1_reg, ok1_reg;
    logic [KW-1:0] k1_reg;

    always_comb
    begin
        pm_c = mag_of(req.p);
        qm_c = mag_of(req.q);
        rm_c = mag_of(req.r);
        mx_c = (pm_c > qm_c) ? pm_c : qm_c;
        mx_c = (rm_c > mx_c) ? rm_c : mx_c;
        k_c  = '0;
        for (int i = NL; i < CW; i++)
        begin
            if (mx_c[i])
            begin
                k_c = KW'(i - NL + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm1_reg <= pm_c;
            qm1_reg <= qm_c;
            rm1_reg <= rm_c;
            ps1_reg <= req.p[CW];
            qs1_reg <= req.q[CW];
            rs1_reg <= req.r[CW];
            ok1_reg <= req.ok;
            k1_reg  <= k_c;
        end
    end

    // Stage 2: shift the magnitudes down together.
    logic [NL-1:0]      pm2_reg, qm2_reg, rm2_reg;
    logic signed [NL:0] pv2_reg, qv2_reg, rv2_reg;
    logic               ok2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm2_reg <= shr(pm1_reg, k1_reg);
            qm2_reg <= shr(qm1_reg, k1_reg);
            rm2_reg <= shr(rm1_reg, k1_reg);
            pv2_reg <= apply_sign(shr(pm1_reg, k1_reg), ps1_reg);
            qv2_reg <= apply_sign(shr(qm1_reg, k1_reg), qs1_reg);
            rv2_reg <= apply_sign(shr(rm1_reg, k1_reg), rs1_reg);
            ok2_reg <= ok1_reg;
        end
    end

    // Stage 3: squares.
    logic [2*NL-1:0]    pp3_reg, qq3_reg, rr3_reg;
    logic signed [NL:0] pv3_reg, qv3_reg, rv3_reg;
    logic               ok3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp3_reg <= pm2_reg * pm2_reg;
            qq3_reg <= qm2_reg * qm2_reg;
            rr3_reg <= rm2_reg * rm2_reg;
            pv3_reg <= pv2_reg;
            qv3_reg <= qv2_reg;
            rv3_reg <= rv2_reg;
            ok3_reg <= ok2_reg;
        end
    end

    // Stage 4: radicand and the real-root test.
    logic [2*NL:0]      hh_c;
    logic [RW-1:0]      rad4_reg;
    logic signed [NL:0] pv4_reg, qv4_reg, rv4_reg;
    logic               ok4_reg;

    assign hh_c = (2*NL+1)'(qq3_reg) + (2*NL+1)'(rr3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad4_reg <= RW'(hh_c - (2*NL+1)'(pp3_reg));
            pv4_reg  <= pv3_reg;
            qv4_reg  <= qv3_reg;
            rv4_reg  <= rv3_reg;
            ok4_reg  <= ok3_reg && ((2*NL+1)'(pp3_reg) <= hh_c);
        end
    end

    // Square root, one result bit per stage from the top.
    logic [RW-1:0]      rem_q  [NL+1];
    logic [NL:0]        root_q [NL+1];
    logic signed [NL:0] pv_q   [NL+1];
    logic signed [NL:0] qv_q   [NL+1];
    logic signed [NL:0] rv_q   [NL+1];
    logic               oks_q  [NL+1];

    for (genvar s = 0; s <= NL; s++)
    begin : g_sqrt
        localparam int J = NL - s;
        logic [RW-1:0]      rem_in;
        logic [NL:0]        root_in;
        logic signed [NL:0] pv_in, qv_in, rv_in;
        logic               ok_in;
        logic [RW-1:0]      cand;

        if (s == 0)
        begin : g_first
            assign rem_in  = rad4_reg;
            assign root_in = '0;
            assign pv_in   = pv4_reg;
            assign qv_in   = qv4_reg;
            assign rv_in   = rv4_reg;
            assign ok_in   = ok4_reg;
        end
        else
        begin : g_next
            assign rem_in  = rem_q[s-1];
            assign root_in = root_q[s-1];
            assign pv_in   = pv_q[s-1];
            assign qv_in   = qv_q[s-1];
            assign rv_in   = rv_q[s-1];
            assign ok_in   = oks_q[s-1];
        end

        assign cand = ((RW'(root_in) << 1) | (RW'(1) << J)) << J;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= cand)
                begin
                    rem_q[s]  <= rem_in - cand;
                    root_q[s] <= root_in | ((NL+1)'(1) << J);
                end
                else
                begin
                    rem_q[s]  <= rem_in;
                    root_q[s] <= root_in;
                end
                pv_q[s]  <= pv_in;
                qv_q[s]  <= qv_in;
                rv_q[s]  <= rv_in;
                oks_q[s] <= ok_in;
            end
        end
    end

    // Pre-rotation: a vector in the left half plane is turned by half a turn.
    logic signed [XW-1:0] ax_q [CS+1];
    logic signed [XW-1:0] ay_q [CS+1];
    logic [ZW-1:0]        az_q [CS+1];
    logic signed [XW-1:0] fx_q [CS+1];
    logic signed [XW-1:0] fy_q [CS+1];
    logic [ZW-1:0]        fz_q [CS+1];
    logic                 okc_q [CS+1];

    logic signed [XW-1:0] fx0_c, fy0_c, ay0_c;

    always_comb
    begin
        ay0_c = -{{(XW-NL-1){pv_q[NL][NL]}}, pv_q[NL]};
        fx0_c = {{(XW-NL-1){rv_q[NL][NL]}}, rv_q[NL]};
        fy0_c = {{(XW-NL-1){qv_q[NL][NL]}}, qv_q[NL]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // The square root is never negative, so the first vector needs no turn.
            ax_q[0] <= $signed({{(XW-NL-1){1'b0}}, root_q[NL]});
            ay_q[0] <= ay0_c;
            az_q[0] <= '0;
            if (fx0_c[XW-1])
            begin
                fx_q[0] <= -fx0_c;
                fy_q[0] <= -fy0_c;
                fz_q[0] <= {1'b1, {(ZW-1){1'b0}}};
            end
            else
            begin
                fx_q[0] <= fx0_c;
                fy_q[0] <= fy0_c;
                fz_q[0] <= '0;
            end
            okc_q[0] <= oks_q[NL];
        end
    end

    // Vectoring rotations, one step per stage for both arctangents.
    for (genvar s = 1; s <= CS; s++)
    begin : g_cordic
        localparam int I = s - 1;
        logic signed [XW-1:0] axs, ays, fxs, fys;
        logic                 a_pos, f_pos;

        assign axs   = ax_q[s-1] >>> I;
        assign ays   = ay_q[s-1] >>> I;
        assign fxs   = fx_q[s-1] >>> I;
        assign fys   = fy_q[s-1] >>> I;
        assign a_pos = !ay_q[s-1][XW-1] && (ay_q[s-1] != '0);
        assign f_pos = !fy_q[s-1][XW-1] && (fy_q[s-1] != '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (a_pos)
                begin
                    ax_q[s] <= ax_q[s-1] + ays;
                    ay_q[s] <= ay_q[s-1] - axs;
                    az_q[s] <= az_q[s-1] + tcas_pkg::atan_entry(I);
                end
                else
                begin
                    ax_q[s] <= ax_q[s-1] - ays;
                    ay_q[s] <= ay_q[s-1] + axs;
                    az_q[s] <= az_q[s-1] - tcas_pkg::atan_entry(I);
                end
                if (f_pos)
                begin
                    fx_q[s] <= fx_q[s-1] + fys;
                    fy_q[s] <= fy_q[s-1] - fxs;
                    fz_q[s] <= fz_q[s-1] + tcas_pkg::atan_entry(I);
                end
                else
                begin
                    fx_q[s] <= fx_q[s-1] - fys;
                    fy_q[s] <= fy_q[s-1] + fxs;
                    fz_q[s] <= fz_q[s-1] - tcas_pkg::atan_entry(I);
                end
                okc_q[s] <= okc_q[s-1];
            end
        end
    end

    // Final stage: combine the angles, round to the output width and sort.
    logic [ZW-1:0] t0_c, t1_c, r0_c, r1_c;
    logic [AW-1:0] e0_c, e1_c;
    logic [ZW-1:0] half_c;
    tcas_pkg::pair_res_t res_reg;

    always_comb
    begin
        half_c = ZW'(1) << (ZW - 1 - AW);
        t0_c   = az_q[CS] - fz_q[CS];
        t1_c   = {1'b1, {(ZW-1){1'b0}}} - az_q[CS] - fz_q[CS];
        r0_c   = t0_c + half_c;
        r1_c   = t1_c + half_c;
        e0_c   = r0_c[ZW-1 -: AW];
        e1_c   = r1_c[ZW-1 -: AW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.found <= okc_q[CS];
            if (!okc_q[CS])
            begin
                res_reg.first  <= '0;
                res_reg.second <= '0;
            end
            else if (e0_c <= e1_c)
            begin
                res_reg.first  <= e0_c;
                res_reg.second <= e1_c;
            end
            else
            begin
                res_reg.first  <= e1_c;
                res_reg.second <= e0_c;
            end
        end
    end

    assign res = res_reg;

endmodule

@@ rtl/core/tcas_back.sv @@
// Back part: pops queued equations and runs both lanes in a stallable pipeline.
module tcas_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  tcas_pkg::work_item_t   q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tcas_pkg::out_item_t    out_data
);

    localparam int LAT = tcas_pkg::LANE_LAT;

    logic [LAT-1:0]       vld_reg, vld_next;
    logic                 adv;
    tcas_pkg::pair_res_t  zero_res, one_res;

    // The pipeline moves whenever its last stage is empty or being taken.
    assign adv   = !vld_reg[LAT-1] || out_ready;
    assign q_pop = adv && !q_empty;

    always_comb
    begin
        vld_next = adv ? {vld_reg[LAT-2:0], !q_empty} : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    tcas_lane u_lane_zero (
        .clk (clk),
        .en  (adv),
        .req (q_data.zero),
        .res (zero_res)
    );

    tcas_lane u_lane_one (
        .clk (clk),
        .en  (adv),
        .req (q_data.one),
        .res (one_res)
    );

    // Result transaction.
    assign out_valid            = vld_reg[LAT-1];
    assign out_data.zero_found  = zero_res.found;
    assign out_data.zero_first  = zero_res.first;
    assign out_data.zero_second = zero_res.second;
    assign out_data.one_found   = one_res.found;
    assign out_data.one_first   = one_res.first;
    assign out_data.one_second  = one_res.second;

endmodule

@@ rtl/core/trig_crossing_angle_solver_unit.sv @@
// Top level of the crossing-angle solver.
// Takes one coefficient transaction per cycle while in_ready is high and returns, for the
// levels zero and one, the sorted pair of angles where a cos/sin contact function crosses
// that level. The input queue entry written at the accepting edge feeds the first lane
// stage, and the lane depth is set by the square root (one stage per result bit) and the
// 31-step CORDIC.
// Throughput is one transaction per cycle; the whole back pipeline holds while a finished
// result waits on out_ready, and the input queue keeps accepting until it fills. The
// tolerance register may be written only while the block is idle.
module trig_crossing_angle_solver_unit #(
    parameter int QUEUE_DEPTH = tcas_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tcas_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output tcas_pkg::out_item_t                out_data,
    input  logic                               cfg_wr_en,
    input  logic [tcas_pkg::TOL_WIDTH-1:0]     cfg_wr_data
);

    tcas_pkg::work_item_t work;
    tcas_pkg::work_item_t q_data;
    logic                 q_full, q_empty, q_pop;

    assign in_ready = !q_full;

    tcas_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (in_data),
        .work        (work)
    );

    tcas_queue #(
        .WIDTH ($bits(tcas_pkg::work_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_data (work),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    tcas_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ rtl/core/tcas_checker.sv @@
// Port-level checks for the crossing-angle solver and their attachment to the top level.
module tcas_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input tcas_pkg::out_item_t  out_data
);

    // A stalled result transaction stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // An absent pair carries zero angles.
    a_zero_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.zero_found |->
            out_data.zero_first == '0 && out_data.zero_second == '0)
        else $error("absent zero pair has nonzero angles");

    a_one_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.one_found |->
            out_data.one_first == '0 && out_data.one_second == '0)
        else $error("absent one pair has nonzero angles");

    // Found pairs come out sorted.
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.zero_first <= out_data.zero_second &&
                      out_data.one_first <= out_data.one_second)
        else $error("angle pair not sorted");

endmodule

bind trig_crossing_angle_solver_unit tcas_checker u_tcas_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
